/* hdl/lco_pkg.sv */
// Lorenz oscillator package: widths, fixed-point constants, job codes, FSM states
// and the packed payload and MAC control structs.
// No dependencies; imported by lco_mac and lorenz_chaotic_oscillator.
`default_nettype none

package lco_pkg;

    // Euler steps per sample tick
    localparam int STEPS  = 100;
    localparam int STEP_W = $clog2(STEPS + 1);

    // field and state widths
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;
    localparam int SCALE_W = 24;
    localparam int RATE_W  = IN_W + 2;   // frequency + modulation
    localparam int ST_W    = 40;         // Q9.30 state
    localparam int FR      = 30;         // state fraction bits
    localparam int Q_SH    = 48;         // step-size fraction bits
    localparam int D_W     = 48;         // saturated increment width
    localparam int Q_W     = 50;         // step size width
    localparam int F_W     = 51;         // derivative width
    localparam int T_W     = 42;         // z * beta term width
    localparam int W_W     = ST_W + 1;   // rho - z, y - x

    // shared multiplier: 64-bit operands split in two 32-bit limbs
    localparam int LIMB_W = 32;
    localparam int OP_W   = 2 * LIMB_W;
    localparam int PP_W   = 2 * LIMB_W + 2;
    localparam int ACC_W  = 100;

    localparam logic [SCALE_W-1:0]     SCALE_RESET = 24'd249322;
    localparam logic signed [ST_W-1:0] X_RESET     = 40'sd107374182;
    localparam logic signed [ST_W-1:0] Y_RESET     = 40'sd214748365;
    localparam logic signed [ST_W-1:0] Z_RESET     = 40'sd322122547;
    localparam logic signed [OP_W-1:0] BETA_Q30    = 64'sd2863311531;
    localparam logic signed [W_W-1:0]  RHO_Q30     = 41'sd30064771072;

    typedef logic signed [OP_W-1:0] lco_op_t;

    // products run through the shared unit, in issue order within a step
    typedef enum logic [3:0] {
        JOB_Q,   // rate * step_scale
        JOB_ZB,  // z * beta
        JOB_XY,  // x * y
        JOB_W2,  // x * (rho - z)
        JOB_DX,  // q * f1
        JOB_DZ,  // q * f3
        JOB_DY,  // q * f2
        JOB_OZ,  // gain * z
        JOB_OY   // gain * y
    } lco_job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_DRAIN
    } lco_state_t;

    typedef struct packed {
        logic [IN_W-1:0]        base_frequency;
        logic signed [IN_W-1:0] modulation_offset;
        logic signed [IN_W-1:0] gain;
    } lco_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] main_sample;
        logic signed [OUT_W-1:0] second_sample;
    } lco_out_t;

    typedef struct packed {
        logic     valid;
        lco_job_t tag;
        lco_op_t  a;
        lco_op_t  b;
    } lco_mac_req_t;

    typedef struct packed {
        logic     ready;
        logic     done;
        lco_job_t tag;
    } lco_mac_status_t;

endpackage

`default_nettype wire

/* hdl/lco_mac.sv */
// Shared 64x64 signed multiply unit built from one 33x33 multiplier, four limb
// products per job, accumulated into a 100-bit sum. Depends on lco_pkg.
`default_nettype none

module lco_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lco_pkg::lco_mac_req_t               req,
    output lco_pkg::lco_mac_status_t            status,
    output logic signed [lco_pkg::ACC_W-1:0]    acc
);
    import lco_pkg::*;

    logic                      busy_reg;
    logic [1:0]                cnt_reg;
    lco_op_t                   op_a_reg;
    lco_op_t                   op_b_reg;
    lco_job_t                  tag_reg;

    logic                      pp_valid_reg;
    logic [1:0]                pp_cnt_reg;
    lco_job_t                  pp_tag_reg;
    logic signed [PP_W-1:0]    pp_reg;

    logic signed [ACC_W-1:0]   acc_reg;
    logic                      done_reg;
    lco_job_t                  done_tag_reg;

    logic                      ready;
    logic                      take;
    logic signed [LIMB_W:0]    a_limb;
    logic signed [LIMB_W:0]    b_limb;
    logic signed [PP_W-1:0]    prod;
    logic signed [ACC_W-1:0]   pp_ext;
    logic signed [ACC_W-1:0]   pp_shifted;
    logic signed [ACC_W-1:0]   acc_next;

    // a new job may enter while the last limb product of the current one issues
    assign ready = !busy_reg || (cnt_reg == 2'd3);
    assign take  = req.valid && ready;

    // cnt: 0 lo*lo, 1 lo*hi, 2 hi*lo, 3 hi*hi
    assign a_limb = cnt_reg[1] ? {op_a_reg[OP_W-1], op_a_reg[OP_W-1:LIMB_W]}
                               : {1'b0, op_a_reg[LIMB_W-1:0]};
    assign b_limb = cnt_reg[0] ? {op_b_reg[OP_W-1], op_b_reg[OP_W-1:LIMB_W]}
                               : {1'b0, op_b_reg[LIMB_W-1:0]};
    assign prod   = a_limb * b_limb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= 2'd0;
            pp_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
            pp_valid_reg <= busy_reg;
            done_reg     <= pp_valid_reg && (pp_cnt_reg == 2'd3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_a_reg <= req.a;
            op_b_reg <= req.b;
            tag_reg  <= req.tag;
        end
        pp_reg       <= prod;
        pp_cnt_reg   <= cnt_reg;
        pp_tag_reg   <= tag_reg;
        done_tag_reg <= pp_tag_reg;
        if (pp_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign pp_ext = {{(ACC_W - PP_W){pp_reg[PP_W-1]}}, pp_reg};

    always_comb
    begin
        unique case (pp_cnt_reg)
            2'd0:    pp_shifted = pp_ext;
            2'd1:    pp_shifted = pp_ext <<< LIMB_W;
            2'd2:    pp_shifted = pp_ext <<< LIMB_W;
            default: pp_shifted = pp_ext <<< (2 * LIMB_W);
        endcase
    end

    // first limb product restarts the sum; wraparound is harmless, results fit
    assign acc_next = ((pp_cnt_reg == 2'd0) ? '0 : acc_reg) + pp_shifted;

    assign status.ready = ready;
    assign status.done  = done_reg;
    assign status.tag   = done_tag_reg;
    assign acc          = acc_reg;

endmodule

`default_nettype wire

/* hdl/lorenz_chaotic_oscillator.sv */
// Lorenz chaotic oscillator top level: sequencer, state registers, writeback
// and output register. Depends on lco_pkg and lco_mac.
//
// Usage:
//   tick channel (tick_valid / tick_stall / tick): one transfer per audio
//     sample, carrying base_frequency, modulation_offset and gain. tick_stall
//     is high while an item is being worked on.
//   result channel (result_valid / result_stall / result): one transfer per
//     tick, main_sample = gain * y and second_sample = gain * z, saturated.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes step_scale; always
//     ready, to be written only while the block is idle.
// Timing: each tick runs 6 * STEPS + 3 products through one shared
//   multiplier, each as four 32-bit limb products; a new product enters
//   as the last limb product of the one before issues. The next tick is
//   taken in the cycle result_valid rises.
// Reset: state returns to x = 0.1, y = 0.2, z = 0.3, step_scale to its
//   default, no result pending.
// Stall: a result waits in the output register while result_stall is high;
//   a following tick is still accepted and computed, and its result waits
//   in the sequencer until the output register is free.
`default_nettype none

module lorenz_chaotic_oscillator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              tick_valid,
    output logic                              tick_stall,
    input  lco_pkg::lco_in_t                  tick,
    output logic                              result_valid,
    input  logic                              result_stall,
    output lco_pkg::lco_out_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lco_pkg::SCALE_W-1:0]       cfg_data
);
    import lco_pkg::*;

    // control
    lco_state_t                 state_reg;
    lco_state_t                 state_next;
    lco_job_t                   job_reg;
    lco_job_t                   job_next;
    logic [STEP_W-1:0]          step_reg;
    logic                       out_valid_reg;

    // configuration and Lorenz state
    logic [SCALE_W-1:0]         scale_reg;
    logic signed [ST_W-1:0]     pos_x_reg;
    logic signed [ST_W-1:0]     pos_y_reg;
    logic signed [ST_W-1:0]     pos_z_reg;

    // per-tick working values
    logic signed [RATE_W-1:0]   rate_reg;
    logic signed [IN_W-1:0]     gain_reg;
    logic signed [Q_W-1:0]      q_reg;
    logic signed [T_W-1:0]      t_reg;
    logic signed [F_W-1:0]      f2_reg;
    logic signed [F_W-1:0]      f3_reg;
    logic signed [OUT_W-1:0]    res_y_reg;
    logic signed [OUT_W-1:0]    res_z_reg;
    lco_out_t                   out_reg;

    logic                       accept;
    logic                       issue;
    logic                       last_step;
    logic                       out_free;
    logic                       out_load;
    logic                       oy_done;
    logic                       mac_valid;

    lco_mac_req_t               mac_req;
    lco_mac_status_t            mac_st;
    logic signed [ACC_W-1:0]    acc;

    logic signed [W_W-1:0]      diff_xy;
    logic signed [F_W-1:0]      f1;
    logic signed [W_W-1:0]      rho_minus_z;

    logic signed [F_W-1:0]      prod30;
    logic signed [F_W-1:0]      f2_new;
    logic signed [F_W-1:0]      f3_new;
    logic [ACC_W-1:Q_SH+D_W-1]  d_top;
    logic signed [D_W-1:0]      delta;
    logic signed [ST_W-1:0]     pos_sel;
    logic signed [D_W:0]        pos_sum;
    logic [D_W:ST_W-1]          sum_top;
    logic signed [ST_W-1:0]     pos_new;
    logic [ACC_W-1:FR+OUT_W-1]  o_top;
    logic signed [OUT_W-1:0]    out_sat;

    lco_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mac_req),
        .status (mac_st),
        .acc    (acc)
    );

    // ---------------------------------------------------------------- FSM

    assign accept    = tick_valid && !tick_stall;
    assign issue     = mac_req.valid && mac_st.ready;
    assign last_step = (step_reg == STEP_W'(STEPS - 1));
    assign out_free  = !out_valid_reg || !result_stall;
    assign oy_done   = mac_st.done && (mac_st.tag == JOB_OY);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue && (job_reg == JOB_OY))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (oy_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        tick_stall = 1'b1;
        mac_valid  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  tick_stall = 1'b0;
            ST_RUN:   mac_valid  = 1'b1;
            ST_WAIT:  ;
            ST_DRAIN: out_load   = out_free;
            default:  ;
        endcase
    end

    // job order: q once, per step z*beta, x*y, x*(rho-z) and the three increments,
    // then gain*z, gain*y; the order keeps every operand ready by its issue cycle
    always_comb
    begin
        unique case (job_reg)
            JOB_Q:   job_next = JOB_ZB;
            JOB_ZB:  job_next = JOB_XY;
            JOB_XY:  job_next = JOB_W2;
            JOB_W2:  job_next = JOB_DX;
            JOB_DX:  job_next = JOB_DZ;
            JOB_DZ:  job_next = JOB_DY;
            JOB_DY:  job_next = last_step ? JOB_OZ : JOB_ZB;
            JOB_OZ:  job_next = JOB_OY;
            default: job_next = JOB_OY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_Q;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            scale_reg     <= SCALE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                job_reg  <= JOB_Q;
                step_reg <= '0;
            end
            else if (issue)
            begin
                job_reg <= job_next;
                if (job_reg == JOB_DY)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                scale_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------ operand select

    assign diff_xy     = W_W'(pos_y_reg) - W_W'(pos_x_reg);
    assign f1          = (F_W'(diff_xy) <<< 3) + (F_W'(diff_xy) <<< 1);  // 10 * (y - x)
    assign rho_minus_z = RHO_Q30 - W_W'(pos_z_reg);

    always_comb
    begin
        mac_req.valid = mac_valid;
        mac_req.tag   = job_reg;
        unique case (job_reg)
            JOB_Q:
            begin
                mac_req.a = OP_W'(rate_reg);
                mac_req.b = lco_op_t'({{(OP_W - SCALE_W){1'b0}}, scale_reg});
            end
            JOB_ZB:
            begin
                mac_req.a = OP_W'(pos_z_reg);
                mac_req.b = BETA_Q30;
            end
            JOB_XY:
            begin
                mac_req.a = OP_W'(pos_x_reg);
                mac_req.b = OP_W'(pos_y_reg);
            end
            JOB_W2:
            begin
                mac_req.a = OP_W'(pos_x_reg);
                mac_req.b = OP_W'(rho_minus_z);
            end
            JOB_DX:
            begin
                mac_req.a = OP_W'(q_reg);
                mac_req.b = OP_W'(f1);
            end
            JOB_DZ:
            begin
                mac_req.a = OP_W'(q_reg);
                mac_req.b = OP_W'(f3_reg);
            end
            JOB_DY:
            begin
                mac_req.a = OP_W'(q_reg);
                mac_req.b = OP_W'(f2_reg);
            end
            JOB_OZ:
            begin
                mac_req.a = OP_W'(gain_reg);
                mac_req.b = OP_W'(pos_z_reg);
            end
            default:
            begin
                mac_req.a = OP_W'(gain_reg);
                mac_req.b = OP_W'(pos_y_reg);
            end
        endcase
    end

    // ----------------------------------------------------------- writeback

    // floor(product / 2^30): these products never exceed the derivative width
    assign prod30 = acc[FR+F_W-1:FR];
    assign f2_new = prod30 - F_W'(pos_y_reg);
    assign f3_new = prod30 - F_W'(t_reg);

    // increment: floor(q * f / 2^48) clamped to 48 bits
    assign d_top = acc[ACC_W-1:Q_SH+D_W-1];
    always_comb
    begin
        if (!(&d_top) && (|d_top))
        begin
            delta = acc[ACC_W-1] ? {1'b1, {(D_W - 1){1'b0}}} : {1'b0, {(D_W - 1){1'b1}}};
        end
        else
        begin
            delta = acc[Q_SH+D_W-1:Q_SH];
        end
    end

    always_comb
    begin
        unique case (mac_st.tag)
            JOB_DX:  pos_sel = pos_x_reg;
            JOB_DY:  pos_sel = pos_y_reg;
            default: pos_sel = pos_z_reg;
        endcase
    end

    // coordinate update, held at the Q9.30 limits
    assign pos_sum = (D_W + 1)'(pos_sel) + (D_W + 1)'(delta);
    assign sum_top = pos_sum[D_W:ST_W-1];
    always_comb
    begin
        if (!(&sum_top) && (|sum_top))
        begin
            pos_new = pos_sum[D_W] ? {1'b1, {(ST_W - 1){1'b0}}} : {1'b0, {(ST_W - 1){1'b1}}};
        end
        else
        begin
            pos_new = pos_sum[ST_W-1:0];
        end
    end

    // output: floor(gain * coordinate / 2^30) clamped to 32 bits
    assign o_top = acc[ACC_W-1:FR+OUT_W-1];
    always_comb
    begin
        if (!(&o_top) && (|o_top))
        begin
            out_sat = acc[ACC_W-1] ? {1'b1, {(OUT_W - 1){1'b0}}} : {1'b0, {(OUT_W - 1){1'b1}}};
        end
        else
        begin
            out_sat = acc[FR+OUT_W-1:FR];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= X_RESET;
            pos_y_reg <= Y_RESET;
            pos_z_reg <= Z_RESET;
        end
        else if (mac_st.done)
        begin
            unique case (mac_st.tag)
                JOB_DX:  pos_x_reg <= pos_new;
                JOB_DY:  pos_y_reg <= pos_new;
                JOB_DZ:  pos_z_reg <= pos_new;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rate_reg <= RATE_W'(tick.base_frequency) + RATE_W'(tick.modulation_offset);
            gain_reg <= tick.gain;
        end
        if (mac_st.done)
        begin
            unique case (mac_st.tag)
                JOB_Q:   q_reg     <= acc[Q_W-1:0];
                JOB_ZB:  t_reg     <= acc[FR+T_W-1:FR];
                JOB_XY:  f3_reg    <= f3_new;
                JOB_W2:  f2_reg    <= f2_new;
                JOB_OZ:  res_z_reg <= out_sat;
                JOB_OY:  res_y_reg <= out_sat;
                default: ;
            endcase
        end
        if (out_load)
        begin
            out_reg.main_sample   <= res_y_reg;
            out_reg.second_sample <= res_z_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
